@@ rtl/met_pkg.sv @@
// Shared types and register codes for the escape-time block.
`timescale 1ns / 1ps
`default_nettype none
package met_pkg;

    localparam logic [1:0] CFG_MAX_ITER = 2'd0;
    localparam logic [1:0] CFG_THRESH   = 2'd1;

    typedef struct packed {
        logic valid;
        logic sat;
    } tok_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/met_mul.sv @@
// Product stage: zr*zr, zi*zi and zr*zi, registered.
`timescale 1ns / 1ps
`default_nettype none
module met_mul #(
    parameter int COORD_WIDTH = 32
) (
    input  wire                             clk,
    input  wire signed [COORD_WIDTH-1:0]    zr,
    input  wire signed [COORD_WIDTH-1:0]    zi,
    output logic signed [2*COORD_WIDTH-1:0] rr,
    output logic signed [2*COORD_WIDTH-1:0] ii,
    output logic signed [2*COORD_WIDTH-1:0] ri
);

    logic signed [2*COORD_WIDTH-1:0] rr_reg;
    logic signed [2*COORD_WIDTH-1:0] ii_reg;
    logic signed [2*COORD_WIDTH-1:0] ri_reg;

    always_ff @(posedge clk)
    begin
        rr_reg <= zr * zr;
        ii_reg <= zi * zi;
        ri_reg <= zr * zi;
    end

    assign rr = rr_reg;
    assign ii = ii_reg;
    assign ri = ri_reg;

endmodule
`default_nettype wire

@@ rtl/met_upd.sv @@
// Update stages: shifted sums plus c, then clamp to the coordinate range.
`timescale 1ns / 1ps
`default_nettype none
module met_upd #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 28
) (
    input  wire                            clk,
    input  wire signed [2*COORD_WIDTH-1:0] rr,
    input  wire signed [2*COORD_WIDTH-1:0] ii,
    input  wire signed [2*COORD_WIDTH-1:0] ri,
    input  wire signed [COORD_WIDTH-1:0]   cr,
    input  wire signed [COORD_WIDTH-1:0]   ci,
    output logic signed [COORD_WIDTH-1:0]  zr,
    output logic signed [COORD_WIDTH-1:0]  zi,
    output logic                           clamped
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    localparam logic signed [PW-1:0] MAXC =
        PW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [PW-1:0] MINC =
        -MAXC - PW'(1);

    logic signed [PW-1:0] dr;
    logic signed [PW-1:0] di;
    logic signed [PW-1:0] pr_next;
    logic signed [PW-1:0] pi_next;
    logic signed [PW-1:0] pr_reg;
    logic signed [PW-1:0] pi_reg;
    logic                 sat_r;
    logic                 sat_i;
    logic signed [COORD_WIDTH-1:0] zr_reg;
    logic signed [COORD_WIDTH-1:0] zi_reg;
    logic                 clamped_reg;

    always_comb
    begin
        dr = PW'(rr) - PW'(ii);
        di = PW'(ri) + PW'(ri);
        pr_next = (dr >>> FRACTION_BITS) + PW'(cr);
        pi_next = (di >>> FRACTION_BITS) + PW'(ci);
        sat_r = (pr_reg > MAXC) || (pr_reg < MINC);
        sat_i = (pi_reg > MAXC) || (pi_reg < MINC);
    end

    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next;
        pi_reg <= pi_next;
        if (pr_reg > MAXC)
        begin
            zr_reg <= MAXC[COORD_WIDTH-1:0];
        end
        else if (pr_reg < MINC)
        begin
            zr_reg <= MINC[COORD_WIDTH-1:0];
        end
        else
        begin
            zr_reg <= pr_reg[COORD_WIDTH-1:0];
        end
        if (pi_reg > MAXC)
        begin
            zi_reg <= MAXC[COORD_WIDTH-1:0];
        end
        else if (pi_reg < MINC)
        begin
            zi_reg <= MINC[COORD_WIDTH-1:0];
        end
        else
        begin
            zi_reg <= pi_reg[COORD_WIDTH-1:0];
        end
        clamped_reg <= sat_r | sat_i;
    end

    assign zr = zr_reg;
    assign zi = zi_reg;
    assign clamped = clamped_reg;

endmodule
`default_nettype wire

@@ rtl/mandelbrot_escape_time_top.sv @@
// Mandelbrot escape-time engine: three-stage iteration ring with control.
// Each iteration passes once around the product / sum / clamp ring.
// Up to three points circulate at once, one per ring slot; the result strobe
// is registered from the stop decision taken in the first ring stage.
// A new item is taken whenever the slot returning from the clamp stage is free.
// Reset (rst_n low, async) empties the ring and loads the default registers.
`timescale 1ns / 1ps
`default_nettype none
module mandelbrot_escape_time_top #(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 28,
    parameter int COUNT_WIDTH   = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_WIDTH-1:0] c_real,
    input  wire signed [COORD_WIDTH-1:0] c_imag,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [1:0]                    cfg_index,
    input  wire [31:0]                   cfg_data,
    output logic                         result_valid,
    output logic                         escaped,
    output logic [COUNT_WIDTH-1:0]       iteration_count,
    output logic                         saturated
);

    localparam int PWD = 2 * COORD_WIDTH;
    localparam int MW  = (2 * COORD_WIDTH + 1 > 31 + FRACTION_BITS) ?
                         2 * COORD_WIDTH + 1 : 31 + FRACTION_BITS;
    localparam int LW  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [63:0] T5 = 64'd5 << FRACTION_BITS;
    localparam logic [30:0] THRESH_RST =
        (T5 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : T5[30:0];
    localparam logic [LW-1:0] CMAX = LW'({COUNT_WIDTH{1'b1}});

    logic [15:0] max_iter_reg;
    logic [30:0] thresh_reg;

    met_pkg::tok_ctrl_t s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg;
    met_pkg::tok_ctrl_t s1_ctrl_next, s2_ctrl_next;
    logic [COUNT_WIDTH-1:0] s1_k_reg, s2_k_reg, s3_k_reg;
    logic [COUNT_WIDTH-1:0] s1_k_next;
    logic signed [COORD_WIDTH-1:0] s1_cr_reg, s1_ci_reg, s2_cr_reg, s2_ci_reg;
    logic signed [COORD_WIDTH-1:0] s3_cr_reg, s3_ci_reg;
    logic signed [COORD_WIDTH-1:0] s1_cr_next, s1_ci_next;
    logic signed [COORD_WIDTH-1:0] mul_zr, mul_zi, upd_zr, upd_zi;
    logic signed [PWD-1:0] rr, ii, ri;
    logic upd_clamped;
    logic accept;
    logic [LW-1:0] miw;
    logic [COUNT_WIDTH-1:0] lim;
    logic [MW-1:0] mag;
    logic [MW-1:0] limit;
    logic esc_now, stop_now;

    logic result_valid_reg, escaped_reg, saturated_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    assign cfg_ready = 1'b1;
    assign busy = s3_ctrl_reg.valid;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= 16'd10000;
            thresh_reg   <= THRESH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == met_pkg::CFG_MAX_ITER)
            begin
                max_iter_reg <= cfg_data[15:0];
            end
            else if (cfg_index == met_pkg::CFG_THRESH)
            begin
                thresh_reg <= cfg_data[30:0];
            end
        end
    end

    always_comb
    begin
        miw = LW'(max_iter_reg);
        lim = COUNT_WIDTH'((miw > CMAX) ? CMAX : miw);
        limit = MW'(thresh_reg) << FRACTION_BITS;
        mag = MW'(rr) + MW'(ii);
        mul_zr = accept ? '0 : upd_zr;
        mul_zi = accept ? '0 : upd_zi;
        s1_cr_next = accept ? c_real : s3_cr_reg;
        s1_ci_next = accept ? c_imag : s3_ci_reg;
        s1_k_next = accept ? '0 : s3_k_reg;
        s1_ctrl_next.valid = accept | s3_ctrl_reg.valid;
        s1_ctrl_next.sat = accept ? 1'b0 : (s3_ctrl_reg.sat | upd_clamped);
        esc_now = s1_ctrl_reg.valid && (s1_k_reg != '0) && (mag > limit);
        stop_now = s1_ctrl_reg.valid && (esc_now || (s1_k_reg == lim));
        s2_ctrl_next.valid = s1_ctrl_reg.valid && !stop_now;
        s2_ctrl_next.sat = s1_ctrl_reg.sat;
    end

    met_mul #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_mul (
        .clk(clk),
        .zr(mul_zr),
        .zi(mul_zi),
        .rr(rr),
        .ii(ii),
        .ri(ri)
    );

    met_upd #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_upd (
        .clk(clk),
        .rr(rr),
        .ii(ii),
        .ri(ri),
        .cr(s1_cr_reg),
        .ci(s1_ci_reg),
        .zr(upd_zr),
        .zi(upd_zi),
        .clamped(upd_clamped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s2_ctrl_next;
            s3_ctrl_reg <= s2_ctrl_reg;
            result_valid_reg <= stop_now;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cr_reg <= s1_cr_next;
        s1_ci_reg <= s1_ci_next;
        s1_k_reg  <= s1_k_next;
        s2_cr_reg <= s1_cr_reg;
        s2_ci_reg <= s1_ci_reg;
        s2_k_reg  <= s1_k_reg + COUNT_WIDTH'(1);
        s3_cr_reg <= s2_cr_reg;
        s3_ci_reg <= s2_ci_reg;
        s3_k_reg  <= s2_k_reg;
        escaped_reg   <= esc_now;
        count_reg     <= esc_now ? s1_k_reg : '0;
        saturated_reg <= s1_ctrl_reg.sat;
    end

    assign result_valid    = result_valid_reg;
    assign escaped         = escaped_reg;
    assign iteration_count = count_reg;
    assign saturated       = saturated_reg;

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_ctrl_reg.valid)
        else $error("accepted item did not enter ring");
    a_bounded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !escaped) |-> (iteration_count == '0))
        else $error("bounded point with nonzero count");
    a_escape_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && escaped) |-> (iteration_count != '0))
        else $error("escape reported at iteration zero");
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (iteration_count <= lim))
        else $error("count beyond limit");
`endif

endmodule
`default_nettype wire
